>>> design/tbgd_pkg.sv
// ----------------------------------------------------------------------------
// tbgd_pkg: shared types and constants
// Field widths, register indexes, mode codes and the structs passed between
// the gesture detector modules.
// ----------------------------------------------------------------------------
package tbgd_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsCfgW  = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 24;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegThreshold = 8'd0;
  localparam logic [CfgIdxW-1:0] RegSettle    = 8'd1;
  localparam logic [CfgIdxW-1:0] RegLongPress = 8'd2;
  localparam logic [CfgIdxW-1:0] RegClickGap  = 8'd3;

  // register reset values
  localparam logic [SampleW-1:0] ThresholdRst = 24'd500;
  localparam logic [MsCfgW-1:0]  SettleRst    = 16'd10;
  localparam logic [MsCfgW-1:0]  LongPressRst = 16'd500;
  localparam logic [MsCfgW-1:0]  ClickGapRst  = 16'd300;

  // mode codes
  localparam logic [ModeW-1:0] ModeIdle  = 3'd0;
  localparam logic [ModeW-1:0] ModeHeld  = 3'd1;
  localparam logic [ModeW-1:0] ModeGap   = 3'd2;
  localparam logic [ModeW-1:0] ModeLong  = 3'd3;
  localparam logic [ModeW-1:0] ModeClick = 3'd4;

  typedef struct packed {
    logic [SampleW-1:0] touch_threshold;
    logic [MsCfgW-1:0]  settle_ms;
    logic [MsCfgW-1:0]  long_press_ms;
    logic [MsCfgW-1:0]  click_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]   now_ms;
    logic [SampleW-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [TimeW-1:0]  hold_ms;
    logic [CountW-1:0] press_count;
    logic              long_valid;
    logic              click_valid;
    logic              release_edge;
    logic              press_edge;
  } result_t;

endpackage

>>> design/tbgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tbgd_cfg_regs: configuration register file
// Four threshold and timing registers written through an indexed port.
// ----------------------------------------------------------------------------
module tbgd_cfg_regs
  import tbgd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [CfgDatW-1:0] wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        RegThreshold: cfg_d.touch_threshold = wr_data_i[SampleW-1:0];
        RegSettle:    cfg_d.settle_ms       = wr_data_i[MsCfgW-1:0];
        RegLongPress: cfg_d.long_press_ms   = wr_data_i[MsCfgW-1:0];
        RegClickGap:  cfg_d.click_gap_ms    = wr_data_i[MsCfgW-1:0];
        default:      cfg_d = cfg_q;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touch_threshold <= ThresholdRst;
      cfg_q.settle_ms       <= SettleRst;
      cfg_q.long_press_ms   <= LongPressRst;
      cfg_q.click_gap_ms    <= ClickGapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/tbgd_core.sv
// ----------------------------------------------------------------------------
// tbgd_core: gesture mode machine
// Edge detection, press counting and click / long press decisions for one
// item; state advances when the item is handed to the result register.
// ----------------------------------------------------------------------------
module tbgd_core
  import tbgd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [ModeW-1:0]  mode_q, mode_d;
  logic [ModeW-1:0]  prior_q;
  logic              touch_q;
  logic [CountW-1:0] count_q, count_d;
  logic [TimeW-1:0]  mark_q, mark_d;

  logic             level, pressed, released, entered;
  logic [TimeW-1:0] diff;
  logic             over_settle, over_long, over_gap;

  assign level    = item_i.sample > cfg_i.touch_threshold;
  assign pressed  = level & ~touch_q;
  assign released = ~level & touch_q;
  assign entered  = prior_q != mode_q;

  // on entry the mark is reloaded with now, so the elapsed time is zero
  assign diff        = entered ? '0 : item_i.now_ms - mark_q;
  assign over_settle = diff > {{(TimeW-MsCfgW){1'b0}}, cfg_i.settle_ms};
  assign over_long   = diff > {{(TimeW-MsCfgW){1'b0}}, cfg_i.long_press_ms};
  assign over_gap    = diff > {{(TimeW-MsCfgW){1'b0}}, cfg_i.click_gap_ms};

  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    mark_d   = mark_q;
    result_o = '0;
    case (mode_q)
      ModeIdle: begin
        count_d = '0;
        if (pressed) mode_d = ModeHeld;
      end
      ModeHeld: begin
        if (entered) begin
          count_d = count_q + 1'b1;
          mark_d  = item_i.now_ms;
        end
        if (released && over_settle) mode_d = ModeGap;
        if (over_long) mode_d = ModeLong;  // long press wins
      end
      ModeGap: begin
        if (entered) mark_d = item_i.now_ms;
        if (pressed) mode_d = ModeHeld;
        if (over_gap) mode_d = ModeClick;  // report wins over new press
      end
      ModeLong: begin
        if (entered) mark_d = item_i.now_ms;
        if (released) mode_d = ModeIdle;
        result_o.long_valid = 1'b1;
        result_o.hold_ms    = diff;
      end
      ModeClick: begin
        result_o.click_valid = 1'b1;
        mode_d = ModeIdle;
      end
      default: mode_d = mode_q;
    endcase
    result_o.press_edge   = pressed;
    result_o.release_edge = released;
    result_o.press_count  = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      prior_q <= ModeIdle;
      touch_q <= 1'b0;
      count_q <= '0;
      mark_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      prior_q <= mode_q;
      touch_q <= level;
      count_q <= count_d;
      mark_q  <= mark_d;
    end
  end

endmodule

>>> design/touch_button_gesture_detector_top.sv
// ----------------------------------------------------------------------------
// touch_button_gesture_detector_top: touch button gesture detector
// Turns a stream of sensor readings with timestamps into press / release
// edges, click series reports and long press reports, one result per item.
// ----------------------------------------------------------------------------
//  channel   | direction | payload (low bit first)
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | sample[23:0], now_ms[55:24]
//  m_axis    | out       | press_edge, release_edge, click_valid, long_valid,
//            |           | press_count[11:4], hold_ms[43:12], zero pad
//  cfg       | in        | index (0..3), data (low bits used)
//
//  one request in, one result out; an accepted request sits in the input
//  register until its result moves into the output register, once that is
//  free or being drained; throughput is one request per cycle while the
//  output is not stalled; the mode machine step is the only logic between
//  the two registers; the input register accepts when it is empty or when
//  its held request moves on to the output register this cycle
//  reset clears both valid flags, the mode state and loads register defaults
//  cfg_ready_o is always high
// ----------------------------------------------------------------------------
module touch_button_gesture_detector_top
  import tbgd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input requests
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // sample[23:0], now_ms[55:24]
  // results
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // press_edge, release_edge,
                                                // click_valid, long_valid,
                                                // press_count[11:4],
                                                // hold_ms[43:12], pad
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  result_t out_q;
  logic    out_valid_q;
  result_t step_result;
  logic    advance;
  logic    in_take;

  // config registers, always writable
  assign cfg_ready_o = 1'b1;

  tbgd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // move the held request into the result register when that one is free
  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign in_take         = s_axis_tvalid_i & s_axis_tready_o;

  // input register: valid flag reset, payload loaded on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.sample <= s_axis_tdata_i[SampleW-1:0];
      in_q.now_ms <= s_axis_tdata_i[SampleW+TimeW-1:SampleW];
    end
  end

  // mode machine, steps exactly once per request
  tbgd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-$bits(result_t)){1'b0}}, out_q};

endmodule

>>> design/tbgd_checker.sv
// ----------------------------------------------------------------------------
// tbgd_checker: port level checks
// Watches the result stream of the gesture detector for inconsistent
// reports and for unstable stalled results.
// ----------------------------------------------------------------------------
module tbgd_checker
  import tbgd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // hold time only travels with a long press report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[3]) |-> (m_axis_tdata_o[43:12] == '0))
    else $error("hold_ms nonzero without long press");

  // click report and long press report come from different modes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[2] && m_axis_tdata_o[3]))
    else $error("click and long press in one result");

  // a click report ends the series, the next result cannot repeat it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tdata_o[2]) ##1 m_axis_tvalid_o
      |-> !m_axis_tdata_o[2])
    else $error("click reported twice in a row");

  // a stalled result holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind touch_button_gesture_detector_top tbgd_checker u_tbgd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
